/* src/ars_pkg.sv */
// ----------------------------------------------------------------------------
// ars_pkg
// Types and constants shared by the actuator reset sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ars_pkg;

    // Field widths
    localparam int SENSE_W  = 10;
    localparam int SETTLE_W = 10;
    localparam int HOLD_W   = 8;
    localparam int QUIET_W  = 8;
    localparam int DUTY_W   = 8;
    localparam int MS_W     = 10;
    localparam int LEG_W    = 2;

    // Reset values of the configuration registers
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 10'd100;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 8'd2;
    localparam logic [QUIET_W-1:0]  QUIET_RESET  = 8'd10;
    localparam logic [SENSE_W-1:0]  THRESH_RESET = 10'd0;

    // Duty levels
    localparam logic [DUTY_W-1:0] DUTY_FULL    = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_TOP     = 8'd254;
    localparam logic [DUTY_W-1:0] DUTY_LOW     = 8'd1;

    // Travel legs
    localparam logic [LEG_W-1:0] LEG_NONE   = 2'd0;
    localparam logic [LEG_W-1:0] LEG_FIRST  = 2'd1;
    localparam logic [LEG_W-1:0] LEG_SECOND = 2'd2;
    localparam logic [LEG_W-1:0] LEG_THIRD  = 2'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SETTLE_MS      = 2'd0,
        REG_RAMP_STEP_MS   = 2'd1,
        REG_QUIET_SAMPLES  = 2'd2,
        REG_ZERO_THRESHOLD = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 10;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_INIT   = 3'd1,
        ST_SETTLE = 3'd2,
        ST_UP     = 3'd3,
        ST_QUIET  = 3'd4,
        ST_DOWN   = 3'd5
    } step_t;

    // One controller tick
    typedef struct packed {
        logic               start_req;
        logic               ms_tick;
        logic [SENSE_W-1:0] sense_value;
    } tick_t;

    // One status result
    typedef struct packed {
        logic [DUTY_W-1:0] pwm_duty;
        logic              drive_forward;
        logic              drive_back;
        logic              busy_res;
        logic              done_res;
        logic [LEG_W-1:0]  leg_number;
    } stat_t;

    // Configuration register set
    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ms;
        logic [HOLD_W-1:0]   ramp_step_ms;
        logic [QUIET_W-1:0]  quiet_samples;
        logic [SENSE_W-1:0]  zero_threshold;
    } cfg_t;

endpackage

`default_nettype wire

/* src/ars_core.sv */
// ----------------------------------------------------------------------------
// ars_core
// Sequencer state and one-pass next-state logic; the registers advance on
// each accepted tick and the status for that tick is presented alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_core #(
    parameter int SENSE_BITS = 10
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            advance,
    input  ars_pkg::tick_t tick,
    input  ars_pkg::cfg_t  cfg,
    output ars_pkg::stat_t stat
);
    import ars_pkg::*;

    localparam int USED_BITS = (SENSE_BITS < SENSE_W) ? SENSE_BITS : SENSE_W;

    step_t               step_reg,  step_next;
    logic [LEG_W-1:0]    leg_reg,   leg_next;
    logic [DUTY_W-1:0]   duty_reg,  duty_next;
    logic [MS_W-1:0]     ms_reg,    ms_next;
    logic [QUIET_W-1:0]  quiet_reg, quiet_next;
    logic                fwd_reg,   fwd_next;
    logic                back_reg,  back_next;
    logic                done;

    logic [SENSE_W-1:0]  sense_used;
    logic [SETTLE_W-1:0] settle_eff;
    logic [HOLD_W-1:0]   hold_eff;
    logic [QUIET_W-1:0]  need_eff;
    logic [MS_W-1:0]     wait_len;
    logic [MS_W-1:0]     ms_inc;
    logic                wait_hit;
    logic [QUIET_W-1:0]  quiet_inc;

    // Mask the sense sample to the converter width
    always_comb
    begin
        sense_used = '0;
        sense_used[USED_BITS-1:0] = tick.sense_value[USED_BITS-1:0];
    end

    // Treat zero lengths as one
    assign settle_eff = (cfg.settle_ms == '0) ? SETTLE_W'(1) : cfg.settle_ms;
    assign hold_eff   = (cfg.ramp_step_ms == '0) ? HOLD_W'(1) : cfg.ramp_step_ms;
    assign need_eff   = (cfg.quiet_samples == '0) ? QUIET_W'(1) : cfg.quiet_samples;

    // Millisecond wait: count a strobe, end when the count reaches the length
    assign wait_len  = ((step_reg == ST_UP) || (step_reg == ST_DOWN))
                       ? MS_W'(hold_eff) : MS_W'(settle_eff);
    assign ms_inc    = ms_reg + MS_W'(1);
    assign wait_hit  = tick.ms_tick && (ms_inc >= wait_len);
    assign quiet_inc = quiet_reg + QUIET_W'(1);

    // Next state for one tick
    always_comb
    begin
        step_next  = step_reg;
        leg_next   = leg_reg;
        duty_next  = duty_reg;
        ms_next    = ms_reg;
        quiet_next = quiet_reg;
        fwd_next   = fwd_reg;
        back_next  = back_reg;
        done       = 1'b0;

        // advance the wait counter in the timed steps
        if ((step_reg == ST_INIT) || (step_reg == ST_SETTLE) ||
            (step_reg == ST_UP) || (step_reg == ST_DOWN))
        begin
            if (wait_hit)
                ms_next = '0;
            else if (tick.ms_tick)
                ms_next = ms_inc;
        end

        unique case (step_reg)
            ST_IDLE:
            begin
                if (tick.start_req)
                begin
                    fwd_next   = 1'b0;
                    back_next  = 1'b0;
                    duty_next  = '0;
                    ms_next    = '0;
                    quiet_next = '0;
                    leg_next   = LEG_NONE;
                    step_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (wait_hit)
                begin
                    leg_next  = LEG_FIRST;
                    fwd_next  = 1'b0;
                    back_next = 1'b1;
                    duty_next = '0;
                    step_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                if (wait_hit)
                begin
                    duty_next = '0;
                    step_next = ST_UP;
                end
            end
            ST_UP:
            begin
                if (wait_hit)
                begin
                    if (duty_reg >= DUTY_TOP)
                    begin
                        duty_next  = DUTY_FULL;
                        quiet_next = '0;
                        step_next  = ST_QUIET;
                    end
                    else
                    begin
                        duty_next = duty_reg + DUTY_W'(1);
                    end
                end
            end
            ST_QUIET:
            begin
                if (sense_used <= cfg.zero_threshold)
                begin
                    if (quiet_inc >= need_eff)
                    begin
                        quiet_next = '0;
                        duty_next  = DUTY_FULL;
                        ms_next    = '0;
                        step_next  = ST_DOWN;
                    end
                    else
                    begin
                        quiet_next = quiet_inc;
                    end
                end
                else
                begin
                    quiet_next = '0;
                end
            end
            ST_DOWN:
            begin
                if (wait_hit)
                begin
                    if (duty_reg <= DUTY_LOW)
                    begin
                        duty_next = '0;
                        if (leg_reg == LEG_FIRST)
                        begin
                            leg_next  = LEG_SECOND;
                            fwd_next  = 1'b1;
                            back_next = 1'b0;
                            step_next = ST_SETTLE;
                        end
                        else if (leg_reg == LEG_SECOND)
                        begin
                            leg_next  = LEG_THIRD;
                            fwd_next  = 1'b0;
                            back_next = 1'b1;
                            step_next = ST_SETTLE;
                        end
                        else
                        begin
                            done      = 1'b1;
                            leg_next  = LEG_NONE;
                            step_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        duty_next = duty_reg - DUTY_W'(1);
                    end
                end
            end
            default:
            begin
                step_next = ST_IDLE;
                leg_next  = LEG_NONE;
                ms_next   = '0;
            end
        endcase
    end

    // Hold state between ticks, advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            leg_reg   <= LEG_NONE;
            duty_reg  <= '0;
            ms_reg    <= '0;
            quiet_reg <= '0;
            fwd_reg   <= 1'b0;
            back_reg  <= 1'b0;
        end
        else if (advance)
        begin
            step_reg  <= step_next;
            leg_reg   <= leg_next;
            duty_reg  <= duty_next;
            ms_reg    <= ms_next;
            quiet_reg <= quiet_next;
            fwd_reg   <= fwd_next;
            back_reg  <= back_next;
        end
    end

    // Status after this tick
    always_comb
    begin
        stat.pwm_duty      = duty_next;
        stat.drive_forward = fwd_next;
        stat.drive_back    = back_next;
        stat.busy_res      = (step_next != ST_IDLE);
        stat.done_res      = done;
        stat.leg_number    = leg_next;
    end

endmodule

`default_nettype wire

/* src/actuator_reset_sequencer_top.sv */
// ----------------------------------------------------------------------------
// actuator_reset_sequencer_top
// Runs the back / forward / back reset travel of an actuator from controller
// ticks and reports drive levels and duty for every tick.
// ----------------------------------------------------------------------------
// Every accepted tick request yields exactly one status request, presented
// from a result register on the clock after acceptance. The block takes one
// tick per clock: the sequencer step is a single pass of logic between the
// state registers and the result register, and tick_stall rises only while
// a finished status is held by stat_stall. Configuration writes are never
// held off (cfg_ready is always high) and should be made while no tick is
// in flight.
`default_nettype none

module actuator_reset_sequencer_top #(
    parameter int SENSE_BITS = 10
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                tick_valid,
    output logic                               tick_stall,
    input  ars_pkg::tick_t                     tick_data,
    output logic                               stat_valid,
    input  wire                                stat_stall,
    output ars_pkg::stat_t                     stat_data,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  ars_pkg::cfg_index_t                cfg_index,
    input  wire [ars_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ars_pkg::*;

    cfg_t  cfg_reg;
    stat_t stat_calc;
    stat_t stat_reg;
    logic  stat_valid_reg;
    logic  accept;

    // Take a tick whenever the result register is free or draining
    assign tick_stall = stat_valid_reg && stat_stall;
    assign accept     = tick_valid && !tick_stall;
    assign cfg_ready  = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ms      <= SETTLE_RESET;
            cfg_reg.ramp_step_ms   <= HOLD_RESET;
            cfg_reg.quiet_samples  <= QUIET_RESET;
            cfg_reg.zero_threshold <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SETTLE_MS:      cfg_reg.settle_ms      <= cfg_data[SETTLE_W-1:0];
                REG_RAMP_STEP_MS:   cfg_reg.ramp_step_ms   <= cfg_data[HOLD_W-1:0];
                REG_QUIET_SAMPLES:  cfg_reg.quiet_samples  <= cfg_data[QUIET_W-1:0];
                REG_ZERO_THRESHOLD: cfg_reg.zero_threshold <= cfg_data[SENSE_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    ars_core #(
        .SENSE_BITS (SENSE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .tick    (tick_data),
        .cfg     (cfg_reg),
        .stat    (stat_calc)
    );

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stat_valid_reg <= 1'b0;
        else if (accept)
            stat_valid_reg <= 1'b1;
        else if (!stat_stall)
            stat_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stat_reg <= stat_calc;
    end

    assign stat_valid = stat_valid_reg;
    assign stat_data  = stat_reg;

endmodule

`default_nettype wire

/* src/ars_checker.sv */
// ----------------------------------------------------------------------------
// ars_checker
// Port-level checks of the actuator reset sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ars_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            tick_valid,
    input wire            tick_stall,
    input wire            stat_valid,
    input wire            stat_stall,
    input ars_pkg::stat_t stat_data
);
    import ars_pkg::*;

    // Never drive both directions at once
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid |-> !(stat_data.drive_forward && stat_data.drive_back))
        else $error("both direction drives asserted");

    // Finish pulse leaves the block idle with no leg
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_valid && stat_data.done_res) |->
            (!stat_data.busy_res && (stat_data.leg_number == LEG_NONE)))
        else $error("done given while still busy");

    // Input backs up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> (stat_valid && stat_stall))
        else $error("tick stalled without a pending result");

    // Every accepted tick gives a result on the next clock
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> stat_valid)
        else $error("no result after accepted tick");

    // Stalled result holds
    a_stat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_valid && stat_stall) |=> (stat_valid && $stable(stat_data)))
        else $error("stalled result changed");

endmodule

bind actuator_reset_sequencer_top ars_checker u_ars_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .stat_valid (stat_valid),
    .stat_stall (stat_stall),
    .stat_data  (stat_data)
);

`default_nettype wire
